// File: hdl/bbpw_pkg.sv
// Package for the bounded bit packer writer.
// Holds store geometry, operation and register codes, and the result struct.
// No dependencies.
package bbpw_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int STORE_BITS  = STORE_BYTES * 8;
  localparam int ROWS        = STORE_BYTES / 8;   // one row = one 32-bit word per bank
  localparam int ROW_W       = $clog2(ROWS);
  localparam int WORD_BITS   = 32'h20;
  localparam int OFF_MASK    = 31;
  localparam int CUR_W       = 16;
  localparam int CFG_W       = 15;
  localparam int NB_W        = 6;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [1:0] CFG_FIRST = 2'd0;
  localparam logic [1:0] CFG_LAST  = 2'd1;
  localparam logic [1:0] CFG_START = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  typedef struct packed {
    logic             stored;
    logic [CUR_W-1:0] total;
    logic [CUR_W-1:0] cursor;
    logic [7:0]       rbyte;
    logic             done;
  } res_t;

endpackage

// File: hdl/bbpw_ram.sv
// One bank of the byte store: ROWS words of 32 bits, one write and one read port.
// Read data is registered. Uses bbpw_pkg.
module bbpw_ram
  import bbpw_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [ROW_W-1:0] waddr,
  input  logic [31:0]      wdata,
  input  logic [ROW_W-1:0] raddr,
  output logic [31:0]      rdata
);

  logic [31:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bbpw_ctrl.sv
// Sequencer of the bit packer: configuration registers, cursor and call state,
// store clearing sweep, and read-modify-write of the two store banks.
// Uses bbpw_pkg; drives two bbpw_ram banks in the top level.
module bbpw_ctrl
  import bbpw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // item side
  input  logic             in_valid,
  output logic             in_ready,
  input  op_t              in_op,
  input  logic [31:0]      in_word,
  input  logic [NB_W-1:0]  in_bits,
  input  logic             in_last,
  input  logic [11:0]      in_addr,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_val,
  // result side
  input  logic             out_free,
  output logic             res_valid,
  output res_t             res,
  // store banks
  output logic             even_we,
  output logic [ROW_W-1:0] even_waddr,
  output logic [31:0]      even_wdata,
  output logic [ROW_W-1:0] even_raddr,
  input  logic [31:0]      even_rdata,
  output logic             odd_we,
  output logic [ROW_W-1:0] odd_waddr,
  output logic [31:0]      odd_wdata,
  output logic [ROW_W-1:0] odd_raddr,
  input  logic [31:0]      odd_rdata
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] first_r, last_bit_r, start_r;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [CUR_W-1:0] call_bits_r, call_bits_nxt;
  logic             stopped_r, stopped_nxt;
  logic [ROW_W-1:0] clr_row_r;

  // captured item
  op_t              op_r;
  logic [NB_W-1:0]  n_r;
  logic             last_r;
  logic [11:0]      addr_r;
  logic             ok_r;
  logic             addr_ok_r;
  logic [63:0]      mask_r;
  logic [63:0]      data_r;

  logic             accept;
  logic             fire;
  logic             clearing;

  // window check and alignment at accept
  logic [NB_W-1:0]  n_clamp;
  logic [16:0]      end_pos;
  logic             win_ok;
  logic [31:0]      low_mask;
  logic [4:0]       off;

  // address generation
  op_t              op_sel;
  logic [11:0]      addr_sel;
  logic [ROW_W:0]   w0;
  logic [ROW_W-1:0] w0_row;
  logic [ROW_W-1:0] rd_row;

  // merge
  logic [31:0]      lo_rd, hi_rd, lo_new, hi_new;
  logic             stored_now;
  logic [31:0]      rd_word;

  assign accept = in_valid && in_ready;
  assign off    = cursor_r[4:0] & 5'(OFF_MASK);

  always_comb begin
    n_clamp  = (in_bits > NB_W'(WORD_BITS)) ? NB_W'(WORD_BITS) : in_bits;
    end_pos  = 17'(cursor_r) + 17'(n_clamp) - 17'd1;
    win_ok   = (n_clamp == '0) ||
               ((end_pos >= 17'(first_r)) && (end_pos <= 17'(last_bit_r)) &&
                ({15'd0, end_pos} < 32'(STORE_BITS)));
    low_mask = (n_clamp >= NB_W'(WORD_BITS)) ? '1 : ((32'd1 << n_clamp) - 32'd1);
  end

  // Issue reads from the arriving item in IDLE, from the held item in ACCESS.
  always_comb begin
    op_sel   = (state_r == ST_IDLE) ? in_op : op_r;
    addr_sel = (state_r == ST_IDLE) ? in_addr : addr_r;
    w0       = (ROW_W+1)'(cursor_r >> 5);
    w0_row   = w0[ROW_W:1];
    rd_row   = ROW_W'(addr_sel >> 3);
    if (op_sel == OP_READ) begin
      even_raddr = rd_row;
      odd_raddr  = rd_row;
    end else begin
      even_raddr = w0[0] ? w0_row + ROW_W'(1) : w0_row;
      odd_raddr  = w0_row;
    end
  end

  always_comb begin
    lo_rd      = w0[0] ? odd_rdata : even_rdata;
    hi_rd      = w0[0] ? even_rdata : odd_rdata;
    lo_new     = (lo_rd & ~mask_r[31:0])  | data_r[31:0];
    hi_new     = (hi_rd & ~mask_r[63:32]) | data_r[63:32];
    stored_now = (op_r == OP_WRITE) && !stopped_r && ok_r;
    rd_word    = addr_r[2] ? odd_rdata : even_rdata;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_row_r == ROW_W'(ROWS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_ACCESS;
      ST_ACCESS: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    clearing  = 1'b0;
    unique case (state_r)
      ST_CLEAR:  clearing  = 1'b1;
      ST_IDLE:   in_ready  = 1'b1;
      ST_ACCESS: res_valid = out_free;
      default:   clearing  = 1'b0;
    endcase
  end

  assign fire = res_valid;

  // bank write ports: zero sweep after reset, merged words on a stored write
  always_comb begin
    if (clearing) begin
      even_we    = 1'b1;
      even_waddr = clr_row_r;
      even_wdata = '0;
      odd_we     = 1'b1;
      odd_waddr  = clr_row_r;
      odd_wdata  = '0;
    end else begin
      even_waddr = even_raddr;
      odd_waddr  = odd_raddr;
      even_wdata = w0[0] ? hi_new : lo_new;
      odd_wdata  = w0[0] ? lo_new : hi_new;
      even_we    = fire && stored_now && (w0[0] ? |mask_r[63:32] : |mask_r[31:0]);
      odd_we     = fire && stored_now && (w0[0] ? |mask_r[31:0] : |mask_r[63:32]);
    end
  end

  // cursor, call state and result
  always_comb begin
    cursor_nxt    = cursor_r;
    call_bits_nxt = call_bits_r;
    stopped_nxt   = stopped_r;
    res           = '0;
    unique case (op_r)
      OP_WRITE: begin
        if (!stopped_r) begin
          if (ok_r) begin
            cursor_nxt    = cursor_r + CUR_W'(n_r);
            call_bits_nxt = call_bits_r + CUR_W'(n_r);
          end else begin
            stopped_nxt = 1'b1;
          end
        end
        res.stored = stored_now;
        res.total  = call_bits_nxt;
        if (last_r) begin
          res.done      = 1'b1;
          call_bits_nxt = '0;
          stopped_nxt   = 1'b0;
        end
      end
      OP_READ: begin
        res.total = call_bits_r;
        res.rbyte = addr_ok_r ? 8'(rd_word >> {addr_r[1:0], 3'b000}) : 8'd0;
      end
      OP_RESTART: begin
        cursor_nxt    = CUR_W'(start_r);
        call_bits_nxt = '0;
        stopped_nxt   = 1'b0;
        res.total     = '0;
      end
      OP_NONE: begin
        res.total = call_bits_r;
      end
      default: res.total = call_bits_r;
    endcase
    res.cursor = cursor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      cursor_r    <= '0;
      call_bits_r <= '0;
      stopped_r   <= 1'b0;
      first_r     <= '0;
      last_bit_r  <= '1;
      start_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_row_r <= clr_row_r + ROW_W'(1);
      end
      if (fire) begin
        cursor_r    <= cursor_nxt;
        call_bits_r <= call_bits_nxt;
        stopped_r   <= stopped_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_FIRST: first_r    <= cfg_val;
          CFG_LAST:  last_bit_r <= cfg_val;
          CFG_START: start_r    <= cfg_val;
          default:   first_r    <= first_r;
        endcase
      end
    end
  end

  // item payload; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      n_r       <= n_clamp;
      last_r    <= in_last;
      addr_r    <= in_addr;
      ok_r      <= win_ok;
      addr_ok_r <= ({20'd0, in_addr} < 32'(STORE_BYTES));
      mask_r    <= {32'd0, low_mask} << off;
      data_r    <= {32'd0, in_word & low_mask} << off;
    end
  end

  // An accepted item is always worked on in the following cycle.
  a_accept_access: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_ACCESS)
    else $error("accepted item not followed by store access");

  // A stored write advances the cursor by exactly its bit count.
  a_cursor_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.stored) |=> cursor_r == $past(cursor_r) + CUR_W'($past(n_r)))
    else $error("cursor did not advance by the stored bit count");

  // A refused write leaves the cursor where it was.
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op_r == OP_WRITE && !res.stored) |=> $stable(cursor_r))
    else $error("refused write moved the cursor");

  // Ending a call restarts the per-call count.
  a_call_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.done) |=> (call_bits_r == '0) && !stopped_r)
    else $error("call state not cleared after last item of call");

endmodule

// File: hdl/bounded_bit_packer_writer.sv
// Top level of the bounded bit packer writer: stream ports, output register,
// and the two store banks. Uses bbpw_pkg, bbpw_ram and bbpw_ctrl.
//
// The block packs words LSB-first into a 4096-byte store at a 16-bit bit cursor
// and answers every input item with exactly one result item. Each item passes
// IDLE, where the store is read as the item is taken, then ACCESS, where the
// words are merged and written back. The store is split into an even-word and
// an odd-word bank of 512 x 32 bits, so the up to five bytes touched by one
// 32-bit word at any bit offset are read together and written back together.
// After reset the block zeroes both banks, one row per cycle, holding in_tready
// low meanwhile; configuration writes are taken throughout, cfg_ready is always
// high. A finished result sits in an output register, so the next item is taken
// while the previous result waits for out_tready. The user must write
// configuration only while no item is in flight; the block does not enforce it.
module bounded_bit_packer_writer
  import bbpw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input items
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [55:0]      in_tdata,   // [31:0] data_word, [37:32] valid_bits,
                                       // [49:38] read_address, [55:50] zero
  input  logic [1:0]       in_tuser,   // [1:0] operation
  input  logic             in_tlast,   // last_of_call
  // result items
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,  // [0] stored, [16:1] call_bit_total,
                                       // [32:17] cursor_now, [40:33] read_byte,
                                       // [47:41] zero
  output logic             out_tlast,  // call_done
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic             out_valid_r;
  res_t             out_res_r;
  logic             out_free;
  logic             res_valid;
  res_t             res;

  logic             even_we, odd_we;
  logic [ROW_W-1:0] even_waddr, even_raddr, odd_waddr, odd_raddr;
  logic [31:0]      even_wdata, even_rdata, odd_wdata, odd_rdata;

  assign cfg_ready = 1'b1;

  // slot frees up when empty or when the waiting item leaves this cycle
  assign out_free = !out_valid_r || out_tready;

  bbpw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (op_t'(in_tuser)),
    .in_word    (in_tdata[31:0]),
    .in_bits    (in_tdata[37:32]),
    .in_last    (in_tlast),
    .in_addr    (in_tdata[49:38]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .even_we    (even_we),
    .even_waddr (even_waddr),
    .even_wdata (even_wdata),
    .even_raddr (even_raddr),
    .even_rdata (even_rdata),
    .odd_we     (odd_we),
    .odd_waddr  (odd_waddr),
    .odd_wdata  (odd_wdata),
    .odd_raddr  (odd_raddr),
    .odd_rdata  (odd_rdata)
  );

  // even 32-bit words of the store (bytes 8r..8r+3 of row r)
  bbpw_ram u_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .raddr (even_raddr),
    .rdata (even_rdata)
  );

  // odd 32-bit words of the store (bytes 8r+4..8r+7 of row r)
  bbpw_ram u_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .raddr (odd_raddr),
    .rdata (odd_rdata)
  );

  // Output register: load a new result, drop the old one once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.done;
  assign out_tdata  = {7'd0, out_res_r.rbyte, out_res_r.cursor, out_res_r.total,
                       out_res_r.stored};

endmodule

// File: verif/tb_bounded_bit_packer_writer.sv
// Testbench for bounded_bit_packer_writer: LSB-first packing into the byte store,
// window refusals and call bookkeeping, checked against a scoreboard with its own
// copy of the store. Depends on bbpw_pkg and the block's RTL only.
import bbpw_pkg::*;

// Scoreboard: mirrors the store, the bit cursor, the call state and the registers,
// and holds the results expected from the block in acceptance order.
class packer_scoreboard;
  logic [7:0]       store_img [STORE_BYTES];
  logic [CUR_W-1:0] bit_pos;
  logic [CUR_W-1:0] call_total;
  logic             call_halted;
  logic [CFG_W-1:0] win_lo;
  logic [CFG_W-1:0] win_hi;
  logic [CFG_W-1:0] restart_pos;
  res_t             pending_results [$];
  int               errors;

  function new();
    foreach (store_img[i]) store_img[i] = 8'h00;
    bit_pos     = '0;
    call_total  = '0;
    call_halted = 1'b0;
    win_lo      = '0;
    win_hi      = 15'h7FFF;
    restart_pos = '0;
    errors      = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_FIRST: win_lo = val;
      CFG_LAST:  win_hi = val;
      CFG_START: restart_pos = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // Apply one accepted item and queue the result it must produce.
  function void predict_item(op_t op, logic [31:0] word, logic [NB_W-1:0] nb,
                             logic last_in, logic [11:0] addr);
    res_t exp_r;
    int   n;
    int   end_pos;
    int   p;
    bit   fits;
    exp_r = '0;
    case (op)
      OP_WRITE: begin
        n = (nb > WORD_BITS) ? WORD_BITS : int'(nb);
        if (!call_halted) begin
          fits = 1'b1;
          if (n != 0) begin
            end_pos = int'(bit_pos) + n - 1;
            fits = (end_pos >= int'(win_lo)) && (end_pos <= int'(win_hi)) &&
                   ((end_pos >> 3) < STORE_BYTES);
            if (fits) begin
              for (int i = 0; i < n; i++) begin
                p = int'(bit_pos) + i;
                store_img[p >> 3][p & 7] = word[i];
              end
              bit_pos = bit_pos + n[CUR_W-1:0];
            end
          end
          if (fits) begin
            exp_r.stored = 1'b1;
            call_total   = call_total + n[CUR_W-1:0];
          end else begin
            call_halted = 1'b1;
          end
        end
        exp_r.total = call_total;
        if (last_in) begin
          exp_r.done  = 1'b1;
          call_total  = '0;
          call_halted = 1'b0;
        end
      end
      OP_READ: begin
        exp_r.rbyte = store_img[addr];
        exp_r.total = call_total;
      end
      OP_RESTART: begin
        bit_pos     = CUR_W'(restart_pos);
        call_total  = '0;
        call_halted = 1'b0;
      end
      default: exp_r.total = call_total;
    endcase
    exp_r.cursor = bit_pos;
    pending_results.push_back(exp_r);
  endfunction

  function void compare_field(string name, logic [CUR_W-1:0] exp_v, logic [CUR_W-1:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endfunction

  function void check_result(res_t got);
    res_t exp_r;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: result with nothing expected, expected none, got %0h", $time, got);
      return;
    end
    exp_r = pending_results.pop_front();
    compare_field("stored",         CUR_W'(exp_r.stored), CUR_W'(got.stored));
    compare_field("call_bit_total", exp_r.total,          got.total);
    compare_field("cursor_now",     exp_r.cursor,         got.cursor);
    compare_field("read_byte",      CUR_W'(exp_r.rbyte),  CUR_W'(got.rbyte));
    compare_field("call_done",      CUR_W'(exp_r.done),   CUR_W'(got.done));
  endfunction
endclass

module tb_bounded_bit_packer_writer;

  localparam int QUIET_LIMIT = 4000;  // covers the clear sweep after reset
  localparam int PHASE_ITEMS = 80;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [55:0]      in_tdata;   // [31:0] data_word, [37:32] valid_bits,
                                // [49:38] read_address, [55:50] zero
  logic [1:0]       in_tuser;   // [1:0] operation
  logic             in_tlast;   // last_of_call
  logic             out_tvalid;
  logic             out_tready;
  logic [47:0]      out_tdata;  // [0] stored, [16:1] call_bit_total,
                                // [32:17] cursor_now, [40:33] read_byte, [47:41] zero
  logic             out_tlast;  // call_done
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  packer_scoreboard sb;
  int               idle_pct;
  bit               no_idle;
  int               stall_left;
  int               quiet_cycles;

  bounded_bit_packer_writer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver: drop out_tready in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every result taken from the block.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tdata[0], out_tdata[16:1], out_tdata[32:17],
                       out_tdata[40:33], out_tlast});
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, optionally after an idle burst, and hold it until taken.
  // in_tvalid stays high afterwards; the next item or stop_items decides.
  task automatic send_item(op_t op, logic [31:0] word, logic [NB_W-1:0] nb,
                           logic last_in, logic [11:0] addr);
    if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last_in;
    in_tdata  <= {6'b0, addr, nb, word};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.predict_item(op, word, nb, last_in, addr);
  endtask

  task automatic stop_items();
    in_tvalid <= 1'b0;
  endtask

  // Hold the sender until every queued result has come back.
  task automatic wait_drained();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Program the whole window and restart position; only called with the block idle.
  task automatic set_window(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                            logic [CFG_W-1:0] st);
    write_reg(CFG_FIRST, lo);
    write_reg(CFG_LAST, hi);
    write_reg(CFG_START, st);
    cfg_valid <= 1'b0;
  endtask

  // Mostly 1..32 bits, with some zero-length and some over-long counts.
  function automatic logic [NB_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return NB_W'($urandom_range(33, 63));
    return NB_W'($urandom_range(1, 32));
  endfunction

  // Byte just behind the cursor, where the latest writes landed.
  function automatic logic [11:0] near_cursor();
    return 12'((sb.bit_pos >> 3) - $urandom_range(0, 4));
  endfunction

  initial begin
    int lo;
    int hi;
    int st;
    int count;
    int calls;
    sb = new();
    idle_pct     = 20;
    no_idle      = 1'b0;
    quiet_cycles = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_WRITE;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_FIRST;
    cfg_data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full window, packing across byte borders.
    set_window(15'd0, 15'h7FFF, 15'd0);
    send_item(OP_READ,    32'h0,         6'd0,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'hFFFF_FFFF, 6'd32, 1'b0, 12'd0);
    send_item(OP_WRITE,   32'h0,         6'd1,  1'b0, 12'd0);
    // upper data bits beyond the count must be ignored
    send_item(OP_WRITE,   32'hFFFF_FF5A, 6'd7,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h1234_5678, 6'd0,  1'b0, 12'd0);
    // over-long count is clipped to a full word; closes the call
    send_item(OP_WRITE,   32'hA5A5_F00F, 6'd63, 1'b1, 12'd0);
    send_item(OP_READ,    32'h0,         6'd0,  1'b0, 12'd4);
    send_item(OP_NONE,    32'hFFFF_FFFF, 6'd63, 1'b1, 12'hFFF);
    send_item(OP_RESTART, 32'h0,         6'd0,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h0000_00C3, 6'd8,  1'b1, 12'd0);
    stop_items();
    wait_drained();

    // Directed: narrow window; refusal halts the call, tail of window is exact.
    set_window(15'd100, 15'd163, 15'd90);
    send_item(OP_RESTART, 32'h0,         6'd0,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h0000_00AB, 6'd8,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h0000_000F, 6'd4,  1'b1, 12'd0);
    send_item(OP_WRITE,   32'h0000_FFFF, 6'd16, 1'b0, 12'd0);
    send_item(OP_WRITE,   32'h0,         6'd32, 1'b0, 12'd0);
    send_item(OP_WRITE,   32'h03FF_FFFF, 6'd26, 1'b0, 12'd0);
    send_item(OP_WRITE,   32'h1,         6'd1,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h0,         6'd0,  1'b1, 12'd0);
    send_item(OP_READ,    32'h0,         6'd0,  1'b0, 12'd11);
    stop_items();
    wait_drained();

    // Directed: last bit of the store, cursor runs to its top value.
    set_window(15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_item(OP_RESTART, 32'h0,         6'd0,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h1,         6'd1,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h1,         6'd1,  1'b1, 12'd0);
    send_item(OP_READ,    32'h0,         6'd0,  1'b0, 12'hFFF);
    stop_items();
    wait_drained();

    // Directed: inverted window refuses everything but a zero-length write.
    set_window(15'd200, 15'd0, 15'd0);
    send_item(OP_RESTART, 32'h0,         6'd0,  1'b0, 12'd0);
    send_item(OP_WRITE,   32'h1F,        6'd5,  1'b1, 12'd0);
    send_item(OP_WRITE,   32'h0,         6'd0,  1'b1, 12'd0);
    stop_items();
    wait_drained();

    // Random phases, each with its own window and idle pressure.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          st = $urandom_range(0, 256);
          lo = 0;
          hi = 32767;
          idle_pct = 30;
        end
        2: begin
          lo = $urandom_range(0, 32767);
          hi = $urandom_range(0, 32767);
          st = lo - $urandom_range(0, 40);
          idle_pct = 50;
        end
        3: begin
          st = $urandom_range(32512, 32767);
          lo = $urandom_range(32000, 32767);
          hi = 32767;
          idle_pct = 20;
        end
        default: begin
          st = $urandom_range(0, 32767);
          lo = st + $urandom_range(0, 48);
          hi = lo + $urandom_range(0, 400);
          idle_pct = (ph == 1) ? 10 : 0;
          no_idle  = (ph == 4);
        end
      endcase
      if (st < 0) st = 0;
      if (lo > 32767) lo = 32767;
      if (hi > 32767) hi = 32767;
      set_window(CFG_W'(lo), CFG_W'(hi), CFG_W'(st));

      count = 0;
      while (count < PHASE_ITEMS) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
          // well-formed call, usually without a restart so the cursor moves on
          if ($urandom_range(0, 99) < 40) begin
            send_item(OP_RESTART, $urandom, 6'($urandom), 1'($urandom), 12'($urandom));
            count++;
          end
          calls = $urandom_range(1, 6);
          for (int k = 0; k < calls; k++) begin
            if ($urandom_range(0, 99) < 15) begin
              send_item(OP_READ, $urandom, 6'($urandom), 1'($urandom), near_cursor());
              count++;
            end
            send_item(OP_WRITE, $urandom, pick_count(), (k == calls - 1), 12'($urandom));
            count++;
          end
        end else if (r < 88) begin
          send_item(OP_READ, $urandom, 6'($urandom), 1'($urandom),
                    ($urandom_range(0, 1) != 0) ? near_cursor() : 12'($urandom));
          count++;
        end else if (r < 93) begin
          // unused operation: the block only reports its state
          send_item(OP_NONE, $urandom, 6'($urandom), 1'($urandom), 12'($urandom));
          count++;
        end else begin
          // broken call: words with no closing item, abandoned later
          calls = $urandom_range(1, 4);
          for (int k = 0; k < calls; k++) begin
            send_item(OP_WRITE, $urandom, pick_count(), 1'b0, 12'($urandom));
            count++;
          end
        end
      end
      stop_items();
      wait_drained();
    end

    // Let any stray result show up before judging.
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
